@@ rtl/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the canonical huffman decoder
// Field widths, mode and status codes, and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int ALPHABET_DEF     = 256;

  localparam int WINDOW_BITS = 16;
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 5;
  localparam int STATUS_W    = 2;
  // one bit above the window so a saturated code never matches
  localparam int CODE_W      = WINDOW_BITS + 1;
  // holds 31 lengths of 511 codes plus an offset inside one length
  localparam int ACC_W       = 14;

  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DECODED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic [WINDOW_BITS-1:0] window;
    logic [CODE_W-1:0]      code;
    logic [ACC_W-1:0]       acc;
    logic                   hit;
    logic [ACC_W-1:0]       pos;
    logic [LEN_W-1:0]       len;
  } tok_t;

endpackage

@@ rtl/chd_ram.sv @@
// ----------------------------------------------------------------------------
// chd_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/chd_cell.sv @@
// ----------------------------------------------------------------------------
// chd_cell: one code length of the canonical walk
// Holds the code count of its length, tests the token's window against its
// code range and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module chd_cell #(
  parameter int LEN = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cnt_we,
  input  logic [chd_pkg::COUNT_W-1:0]  cnt_wdata,
  input  chd_pkg::tok_t                tok_in,
  output chd_pkg::tok_t                tok_out
);

  import chd_pkg::*;

  logic [COUNT_W-1:0]  cnt;
  logic [CODE_W-1:0]   w;
  logic [CODE_W-1:0]   diff;
  logic                here;
  logic [CODE_W:0]     sum;
  logic [CODE_W+1:0]   shifted;
  tok_t                tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt_we) begin
      cnt <= cnt_wdata;
    end
  end

  generate
    if (LEN <= WINDOW_BITS) begin : g_cmp
      localparam int SHIFT = WINDOW_BITS - LEN;
      assign w = {1'b0, tok_in.window >> SHIFT};
    end else begin : g_nocmp
      // lengths past the window never match
      assign w = '0;
    end
  endgenerate

  assign diff = w - tok_in.code;
  assign here = (LEN <= WINDOW_BITS) && (w >= tok_in.code) &&
                (diff < CODE_W'(cnt));
  assign sum     = {1'b0, tok_in.code} + (CODE_W+1)'(cnt);
  assign shifted = {sum, 1'b0};

  always_comb begin
    tok_next       = tok_in;
    tok_next.acc   = tok_in.acc + ACC_W'(cnt);
    // saturate: once the code passes the window range nothing further matches
    if (shifted[CODE_W+1:CODE_W] != 2'b00) begin
      tok_next.code = '1;
    end else begin
      tok_next.code = shifted[CODE_W-1:0];
    end
    if (!tok_in.hit && here) begin
      tok_next.hit = 1'b1;
      tok_next.pos = tok_in.acc + ACC_W'(diff[COUNT_W-1:0]);
      tok_next.len = LEN_W'(LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/canonical_huffman_decoder_top.sv @@
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_top: canonical huffman decoder
// A transaction is taken when start is high and busy is low. Mode 0 writes the
// code count of length index+1, mode 1 writes the symbol at canonical position
// index, mode 2 decodes the left-aligned window, mode 3 does nothing.
// Each transaction gives exactly one result, shown for one cycle with done
// high: symbol, code_length and status (decoded, no match, load accepted).
// Loads and mode 3 answer in the cycle after acceptance. A decode token is
// registered at the head, walks a chain of MAX_CODE_LEN registered cells, one
// code length per cell, then reads the symbol ram as the result is registered.
// One transaction is in flight at a time; busy drops in the cycle where done
// is high, so the next transaction can be taken there.
// The receiver cannot stall: results are never held off.
// Reset clears the code counts and the control state; the symbol table is
// undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_top #(
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
  parameter int ALPHABET     = chd_pkg::ALPHABET_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [chd_pkg::MODE_W-1:0]      mode,
  input  logic [chd_pkg::INDEX_W-1:0]     index,
  input  logic [chd_pkg::COUNT_W-1:0]     value,
  input  logic [chd_pkg::WINDOW_BITS-1:0] window,
  output logic                            done,
  output logic [chd_pkg::SYM_W-1:0]       symbol,
  output logic [chd_pkg::LEN_W-1:0]       code_length,
  output logic [chd_pkg::STATUS_W-1:0]    status
);

  import chd_pkg::*;

  localparam int ADDR_W = $clog2(ALPHABET);

  logic                accept;
  logic                in_flight;
  tok_t                head;
  tok_t                chain [0:MAX_CODE_LEN];
  logic [MAX_CODE_LEN:0] tok_valid;
  tok_t                tail;

  logic                sym_we;
  logic [ADDR_W-1:0]   raddr;
  logic [SYM_W-1:0]    rdata;

  logic                fin_valid, fin_valid_next;
  logic [STATUS_W-1:0] fin_status, fin_status_next;
  logic [LEN_W-1:0]    fin_len, fin_len_next;
  logic                fin_use_ram, fin_use_ram_next;

  assign accept = start && !busy;
  assign busy   = in_flight && !fin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
    end else if (accept) begin
      in_flight <= 1'b1;
    end else if (fin_valid) begin
      in_flight <= 1'b0;
    end
  end

  // head of the chain: a fresh token for a decode transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid  <= accept && (mode == MODE_DECODE);
      head.window <= window;
      head.code   <= '0;
      head.acc    <= '0;
      head.hit    <= 1'b0;
      head.pos    <= '0;
      head.len    <= '0;
    end
  end

  assign chain[0] = head;

  genvar i;
  generate
    for (i = 0; i < MAX_CODE_LEN; i++) begin : g_cell
      chd_cell #(
        .LEN(i + 1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cnt_we    (accept && (mode == MODE_COUNT) && (index == INDEX_W'(i))),
        .cnt_wdata (value),
        .tok_in    (chain[i]),
        .tok_out   (chain[i+1])
      );
    end
    for (i = 0; i <= MAX_CODE_LEN; i++) begin : g_vld
      assign tok_valid[i] = chain[i].valid;
    end
  endgenerate

  assign tail = chain[MAX_CODE_LEN];

  assign sym_we = accept && (mode == MODE_SYMBOL) &&
                  ({1'b0, index} < (INDEX_W+1)'(ALPHABET));

  // single-symbol table reads position zero
  assign raddr = (tail.acc == ACC_W'(1)) ? '0 : tail.pos[ADDR_W-1:0];

  chd_ram #(
    .WIDTH(SYM_W),
    .DEPTH(ALPHABET)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (index[ADDR_W-1:0]),
    .wdata (value[SYM_W-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    fin_valid_next   = 1'b0;
    fin_status_next  = ST_NOMATCH;
    fin_len_next     = '0;
    fin_use_ram_next = 1'b0;
    if (accept && (mode != MODE_DECODE)) begin
      fin_valid_next = 1'b1;
      if (mode == MODE_COUNT || mode == MODE_SYMBOL) begin
        fin_status_next = ST_LOADED;
      end
    end else if (tail.valid) begin
      fin_valid_next = 1'b1;
      if (tail.acc == ACC_W'(1)) begin
        fin_status_next  = ST_DECODED;
        fin_use_ram_next = 1'b1;
      end else if (tail.hit && (tail.pos < ACC_W'(ALPHABET))) begin
        fin_status_next  = ST_DECODED;
        fin_len_next     = tail.len;
        fin_use_ram_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= fin_valid_next;
    end
    fin_status  <= fin_status_next;
    fin_len     <= fin_len_next;
    fin_use_ram <= fin_use_ram_next;
  end

  assign done        = fin_valid;
  assign status      = fin_status;
  assign code_length = fin_len;
  assign symbol      = fin_use_ram ? rdata : '0;

`ifndef SYNTHESIS
  // at most one decode token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the cell chain");

  a_done_in_flight: assert property (@(posedge clk) disable iff (rst)
    done |-> in_flight)
    else $error("result without a transaction in flight");

  a_load_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode != MODE_DECODE)) |=> (done && (status != ST_DECODED)))
    else $error("load transaction not answered in the next cycle");

  a_quiet_fail: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_DECODED)) |-> ((symbol == '0) && (code_length == '0)))
    else $error("non-decode result carries symbol or length");
`endif

endmodule

@@ dv/canonical_huffman_decoder_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_top_test: self-checking bench for the decoder
// Loads code tables (incompressible, single code, empty, complete, sparse and
// overfull), decodes plain and code-aligned windows, and checks every result
// against a behavioural copy of the canonical walk kept inside the bench.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_top_test;
  import chd_pkg::*;

  localparam int NLEN         = MAX_CODE_LEN_DEF;
  localparam int NSYM         = ALPHABET_DEF;
  localparam int ITEM_TARGET  = 1450;
  localparam int SETTLE       = 2 * (MAX_CODE_LEN_DEF + 2) + 8;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  localparam int KIND_IDENTITY = 0;
  localparam int KIND_SINGLE   = 1;
  localparam int KIND_EMPTY    = 2;
  localparam int KIND_OVERFULL = 3;
  localparam int KIND_SPARSE   = 4;
  localparam int KIND_FULL     = 5;

  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [COUNT_W-1:0]     value_t;
  typedef logic [WINDOW_BITS-1:0] window_t;
  typedef logic [SYM_W-1:0]       sym_t;
  typedef value_t                 count_tab_t [NLEN];

  typedef struct {
    mode_t   mode;
    index_t  index;
    value_t  value;
    window_t window;
    int      gap;
    bit      drain;
  } huff_cmd_t;

  typedef struct {
    sym_t                 symbol;
    logic [LEN_W-1:0]     code_length;
    logic [STATUS_W-1:0]  status;
  } huff_res_t;

  logic                   clk    = 1'b0;
  logic                   rst    = 1'b1;
  logic                   start  = 1'b0;
  logic                   busy;
  mode_t                  mode   = MODE_COUNT;
  index_t                 index  = '0;
  value_t                 value  = '0;
  window_t                window = '0;
  logic                   done;
  sym_t                   symbol;
  logic [LEN_W-1:0]       code_length;
  logic [STATUS_W-1:0]    status;

  // decoder state as the bench sees it at each accepted transaction
  count_tab_t live_counts;
  sym_t       live_symbols [NSYM];

  // state as it will be when each planned transaction is reached
  count_tab_t plan_counts;
  bit         plan_written [NSYM];

  huff_cmd_t command_q [$];
  huff_res_t pending_answers [$];
  huff_cmd_t staged_cmd;
  huff_cmd_t active_cmd;
  bit        staged      = 1'b0;
  int        gap_left    = 0;
  int        burst_left  = 0;
  int        planned     = 0;
  int        failures    = 0;
  int        cycle_count = 0;

  always #6 clk = ~clk;

  canonical_huffman_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .index       (index),
    .value       (value),
    .window      (window),
    .done        (done),
    .symbol      (symbol),
    .code_length (code_length),
    .status      (status)
  );

  // canonical walk: shortest length whose code range holds the window wins
  function automatic void walk_code(input count_tab_t cnts, input window_t win,
                                    output bit single, output bit hit,
                                    output int pos, output int len);
    int     total;
    int     first;
    longint code;
    longint w;
    total = 0;
    first = 0;
    code  = 0;
    hit   = 1'b0;
    pos   = 0;
    len   = 0;
    foreach (cnts[i]) total += int'(cnts[i]);
    single = (total == 1);
    if (!single) begin
      for (int l = 1; l <= NLEN; l++) begin
        w = longint'(win) >> (WINDOW_BITS - l);
        if (!hit && w >= code && (w - code) < longint'(cnts[l-1])) begin
          hit = 1'b1;
          pos = first + int'(w - code);
          len = l;
        end
        first += int'(cnts[l-1]);
        code = (code + longint'(cnts[l-1])) << 1;
      end
    end
  endfunction

  function automatic huff_res_t apply_command(input huff_cmd_t c);
    huff_res_t r;
    bit        single;
    bit        hit;
    int        pos;
    int        len;
    r.symbol      = '0;
    r.code_length = '0;
    r.status      = ST_LOADED;
    case (c.mode)
      MODE_COUNT: begin
        if (int'(c.index) < NLEN) live_counts[int'(c.index)] = c.value;
      end
      MODE_SYMBOL: begin
        if (int'(c.index) < NSYM) live_symbols[int'(c.index)] = c.value[SYM_W-1:0];
      end
      MODE_DECODE: begin
        walk_code(live_counts, c.window, single, hit, pos, len);
        if (single) begin
          r.symbol = live_symbols[0];
          r.status = ST_DECODED;
        end else if (hit && pos < NSYM) begin
          r.symbol      = live_symbols[pos];
          r.code_length = LEN_W'(len);
          r.status      = ST_DECODED;
        end else begin
          r.status = ST_NOMATCH;
        end
      end
      default: r.status = ST_NOMATCH;
    endcase
    return r;
  endfunction

  task automatic plan(input mode_t m, input index_t idx, input value_t val,
                      input window_t win, input bit drain);
    huff_cmd_t c;
    bit        single;
    bit        hit;
    int        pos;
    int        len;
    int        need;
    c.mode   = m;
    c.index  = idx;
    c.value  = val;
    c.window = win;
    c.drain  = drain;
    if (m == MODE_DECODE) begin
      walk_code(plan_counts, win, single, hit, pos, len);
      need = single ? 0 : ((hit && pos < NSYM) ? pos : -1);
      // never read a symbol entry that has not been written: load it instead
      if (need >= 0 && !plan_written[need]) begin
        c.mode  = MODE_SYMBOL;
        c.index = index_t'(need);
        c.value = value_t'($urandom);
      end
    end
    if (c.mode == MODE_COUNT && int'(c.index) < NLEN) plan_counts[int'(c.index)] = c.value;
    if (c.mode == MODE_SYMBOL && int'(c.index) < NSYM) plan_written[int'(c.index)] = 1'b1;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      c.gap = $urandom_range(1, 24);
    end else begin
      c.gap = 0;
    end
    burst_left--;
    // a draining transaction never goes out back to back with the previous accept
    if (drain && c.gap == 0) c.gap = 1;
    if (!(c.mode == MODE_NOP || (c.mode == MODE_COUNT && int'(c.index) >= NLEN))) planned++;
    command_q.push_back(c);
  endtask

  // complete prefix code: split random leaves until there are n of them
  task automatic build_tree(input int n, output count_tab_t t);
    int leaves [NLEN+1];
    int d;
    foreach (leaves[i]) leaves[i] = 0;
    leaves[0] = 1;
    repeat (n - 1) begin
      do d = $urandom_range(0, NLEN - 1); while (leaves[d] == 0);
      leaves[d]--;
      leaves[d+1] += 2;
    end
    for (int l = 1; l <= NLEN; l++) t[l-1] = value_t'(leaves[l]);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 7))
      0, 1: plan(MODE_NOP, index_t'($urandom), value_t'($urandom), window_t'($urandom), 1'b0);
      2, 3: plan(MODE_COUNT, index_t'($urandom_range(NLEN, 255)), value_t'($urandom),
                 window_t'($urandom), 1'b0);
      4, 5, 6: plan(MODE_SYMBOL, index_t'($urandom), value_t'($urandom),
                    window_t'($urandom), 1'b0);
      default: plan(MODE_COUNT, index_t'($urandom_range(0, NLEN - 1)), value_t'($urandom),
                    window_t'($urandom), 1'b0);
    endcase
  endtask

  task automatic run_table(input int kind);
    count_tab_t t;
    int         total;
    int         nsym;
    int         ndec;
    int         l;
    int         v;
    int         pos;
    int         first;
    bit         hit;
    longint     code;
    window_t    win;
    foreach (t[i]) t[i] = '0;
    case (kind)
      KIND_IDENTITY: t[7] = value_t'(NSYM);
      KIND_SINGLE:   t[$urandom_range(0, NLEN - 1)] = value_t'(1);
      KIND_EMPTY:    ;
      default: begin
        build_tree(($urandom_range(0, 5) == 0) ? $urandom_range(25, NSYM)
                                                : $urandom_range(2, 24), t);
        if (kind == KIND_OVERFULL) begin
          l = $urandom_range(0, NLEN - 1);
          v = int'(t[l]) + $urandom_range(1, 300);
          t[l] = value_t'((v > 511) ? 511 : v);
        end else if (kind == KIND_SPARSE) begin
          do l = $urandom_range(0, NLEN - 1); while (t[l] == 0);
          t[l] = value_t'(int'(t[l]) - int'($urandom_range(1, int'(t[l]))));
        end
      end
    endcase
    total = 0;
    for (int i = 0; i < NLEN; i++) begin
      total += int'(t[i]);
      plan(MODE_COUNT, index_t'(i), t[i], window_t'($urandom),
           i == 0 && $urandom_range(0, 3) == 0);
    end
    nsym = (total < NSYM) ? total : NSYM;
    for (int p = 0; p < nsym; p++) begin
      if (kind == KIND_IDENTITY)
        plan(MODE_SYMBOL, index_t'(p), {1'($urandom), sym_t'(p)}, window_t'($urandom), 1'b0);
      else
        plan(MODE_SYMBOL, index_t'(p), value_t'($urandom), window_t'($urandom), 1'b0);
    end
    ndec = (kind == KIND_EMPTY) ? 8 : $urandom_range(20, 60);
    repeat (ndec) begin
      if ($urandom_range(0, 11) == 0) begin
        noise_item();
      end else begin
        win = window_t'($urandom);
        // half the windows start with a chosen code and random trailing bits
        if (nsym > 0 && $urandom_range(0, 1) == 1) begin
          pos   = $urandom_range(0, nsym - 1);
          first = 0;
          code  = 0;
          hit   = 1'b0;
          for (int k = 1; k <= NLEN; k++) begin
            if (!hit && pos < first + int'(t[k-1])) begin
              win = window_t'(((code + pos - first) << (WINDOW_BITS - k)) |
                              (longint'(win) & ((longint'(1) << (WINDOW_BITS - k)) - 1)));
              hit = 1'b1;
            end
            first += int'(t[k-1]);
            code = (code + longint'(t[k-1])) << 1;
          end
        end
        plan(MODE_DECODE, index_t'($urandom), value_t'($urandom), win, 1'b0);
      end
    end
  endtask

  // driver: one transaction presented at a time, start held until accepted
  always @(posedge clk) begin
    logic next_start;
    bit   go;
    go = 1'b0;
    next_start = 1'b0;
    if (rst) begin
      foreach (live_counts[i]) live_counts[i] = '0;
    end else begin
      if (start && !busy) pending_answers.push_back(apply_command(active_cmd));
      if (start && busy) begin
        next_start = 1'b1;
      end else begin
        if (!staged && command_q.size() != 0) begin
          staged_cmd = command_q.pop_front();
          staged     = 1'b1;
          gap_left   = staged_cmd.gap;
        end
        if (staged) begin
          if (gap_left > 0)
            gap_left--;
          else if (!staged_cmd.drain || pending_answers.size() == 0 ||
                   (pending_answers.size() == 1 && done))
            go = 1'b1;
        end
      end
      if (go) begin
        mode       <= staged_cmd.mode;
        index      <= staged_cmd.index;
        value      <= staged_cmd.value;
        window     <= staged_cmd.window;
        active_cmd = staged_cmd;
        staged     = 1'b0;
        next_start = 1'b1;
      end
    end
    start <= next_start;
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    huff_res_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: symbol %0d code_length %0d status %0d",
               symbol, code_length, status);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (symbol !== want.symbol) begin
          $error("symbol: expected %0d, actual %0d", want.symbol, symbol);
          failures++;
        end
        if (code_length !== want.code_length) begin
          $error("code_length: expected %0d, actual %0d", want.code_length, code_length);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          failures++;
        end
      end
    end
  end

  initial begin
    int kind;
    bit first_table;
    foreach (plan_counts[i]) plan_counts[i] = '0;
    foreach (plan_written[i]) plan_written[i] = 1'b0;

    // empty table, unused mode, ignored length write
    plan(MODE_DECODE, 8'h00, 9'h000, 16'hFFFF, 1'b0);
    plan(MODE_NOP,    8'hFF, 9'h1FF, 16'hFFFF, 1'b0);
    plan(MODE_COUNT,  8'hF0, 9'h1FF, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'hFF, 9'h1FF, 16'h0000, 1'b0);
    // single code at length 16: the symbol at position 0 whatever the window, length 0
    plan(MODE_SYMBOL, 8'h00, 9'h1AB, 16'h5A5A, 1'b0);
    plan(MODE_SYMBOL, 8'hFF, 9'h0FF, 16'hA5A5, 1'b0);
    plan(MODE_COUNT,  8'h0F, 9'h001, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h1234, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'hFFFF, 1'b0);
    plan(MODE_COUNT,  8'h0F, 9'h000, 16'h0000, 1'b1);
    // two codes of length one, then overfull at length one
    plan(MODE_COUNT,  8'h00, 9'h002, 16'h0000, 1'b0);
    plan(MODE_SYMBOL, 8'h01, 9'h0CD, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'hFFFF, 1'b0);
    plan(MODE_COUNT,  8'h00, 9'h003, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h8000, 1'b0);
    // 511 codes of length nine: positions past the alphabet give no match
    plan(MODE_COUNT,  8'h00, 9'h000, 16'h0000, 1'b0);
    plan(MODE_COUNT,  8'h08, 9'h1FF, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h0000, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'hFFFF, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h9600, 1'b0);
    plan(MODE_DECODE, 8'h00, 9'h000, 16'h7F80, 1'b0);
    plan(MODE_COUNT,  8'h08, 9'h000, 16'h0000, 1'b0);

    first_table = 1'b1;
    while (planned < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       kind = KIND_IDENTITY;
        1:       kind = KIND_SINGLE;
        2:       kind = KIND_EMPTY;
        3, 4:    kind = KIND_OVERFULL;
        5, 6:    kind = KIND_SPARSE;
        default: kind = KIND_FULL;
      endcase
      run_table(first_table ? KIND_IDENTITY : kind);
      first_table = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (command_q.size() != 0 || staged || start || pending_answers.size() != 0);
    repeat (SETTLE) @(negedge clk);

    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
